// File: hdl/darms_pkg.sv
// Package for the torsion-angle RMS deviation block.
// Shared widths, constants and sequencer state types; no dependencies.
package darms_pkg;

  // pi * 2^61, truncated; pi and two pi are rounded from this at elaboration
  localparam logic [63:0] PI_SCALED_61 = 64'h6487ED5110B4611A;

  localparam int ANGLE_W = 16;
  localparam int DIFF_W  = 17;          // |b - a| and the wrapped difference
  localparam int SQ_W    = 2 * DIFF_W;  // exact square
  localparam int CONST_W = 34;          // pi / two pi at up to 31 fraction bits
  localparam int SUM_W   = 42;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 3;  // shared subtractor width
  localparam int RMS_W   = 15;
  localparam int PC_W    = 13;
  localparam int STEP_W  = 6;

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [RMS_W-1:0] RMS_MAX = '1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIFF = 7'b0000010,
    ST_WRAP = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_ACC  = 7'b0010000,
    ST_KICK = 7'b0100000,
    ST_WAIT = 7'b1000000
  } seq_state_t;

  typedef enum logic [2:0] {
    US_IDLE = 3'b001,
    US_DIV  = 3'b010,
    US_SQRT = 3'b100
  } unit_state_t;

endpackage

// File: hdl/darms_divsqrt.sv
// Iterative mean and root unit: restoring divide, then digit-by-digit
// integer square root, both on one shared subtractor. Uses darms_pkg.
module darms_divsqrt #(
  parameter int DIV_W = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [darms_pkg::SUM_W-1:0]   dividend,
  input  logic [DIV_W-1:0]              divisor,
  output logic                          done,
  output logic [darms_pkg::ROOT_W-1:0]  root
);

  localparam int SUM_W  = darms_pkg::SUM_W;
  localparam int ROOT_W = darms_pkg::ROOT_W;
  localparam int REM_W  = darms_pkg::REM_W;
  localparam int STEP_W = darms_pkg::STEP_W;

  darms_pkg::unit_state_t state_r, state_nxt;
  logic [SUM_W-1:0]  qr_r, qr_nxt;     // dividend/quotient, then radicand
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;

  logic [REM_W-1:0]  sh_div, sh_sqrt, opa, opb;
  logic [REM_W:0]    dif;
  logic              ge;

  always_comb begin
    sh_div  = {rem_r[REM_W-2:0], qr_r[SUM_W-1]};
    sh_sqrt = {rem_r[REM_W-3:0], qr_r[SUM_W-1 -: 2]};
    if (state_r == darms_pkg::US_DIV) begin
      opa = sh_div;
      opb = REM_W'(divisor);
    end else begin
      opa = sh_sqrt;
      opb = REM_W'({root_r, 2'b01});
    end
    dif = {1'b0, opa} - {1'b0, opb};
    ge  = !dif[REM_W];
  end

  always_comb begin
    state_nxt = state_r;
    qr_nxt    = qr_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    case (state_r)
      darms_pkg::US_IDLE: begin
        if (start) begin
          qr_nxt    = dividend;
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = darms_pkg::US_DIV;
        end
      end
      darms_pkg::US_DIV: begin
        rem_nxt  = ge ? dif[REM_W-1:0] : sh_div;
        qr_nxt   = {qr_r[SUM_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(darms_pkg::DIV_STEPS - 1)) begin
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = darms_pkg::US_SQRT;
        end
      end
      darms_pkg::US_SQRT: begin
        rem_nxt  = ge ? dif[REM_W-1:0] : sh_sqrt;
        root_nxt = {root_r[ROOT_W-2:0], ge};
        qr_nxt   = {qr_r[SUM_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(darms_pkg::SQRT_STEPS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = darms_pkg::US_IDLE;
        end
      end
      default: begin
        state_nxt = darms_pkg::US_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= darms_pkg::US_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      step_r  <= step_nxt;
    end
    qr_r   <= qr_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

  a_done_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r == darms_pkg::US_SQRT))
    else $error("root done without a square root pass");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("root done held longer than one cycle");

endmodule

// File: hdl/dihedral_angle_rms_distance.sv
// Top level: circular RMS deviation of paired torsion angles.
// Depends on darms_pkg and darms_divsqrt (shared divide / square root unit).
//
//  channel | ports                                           | handshake
//  --------+-------------------------------------------------+----------------------
//  input   | in_angle_a, in_angle_b, in_last_pair            | start && !busy
//  result  | out_rms_angle, out_pair_count, out_count_overflow| out_valid strobe
//
// After a pair is accepted, the sequencer steps through difference,
// wrap, square and accumulate, then returns to idle for the next accept. A last
// pair adds a kick state and a wait for the bit-serial divide and square root
// sharing one 24-bit subtractor.
// Reset is synchronous; it clears the sequencer, sum, count and overflow.
// Results cannot be stalled: out_valid is high for exactly one cycle.
module dihedral_angle_rms_distance #(
  parameter int MAX_ANGLES      = 4096,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [darms_pkg::ANGLE_W-1:0] in_angle_a,
  input  logic signed [darms_pkg::ANGLE_W-1:0] in_angle_b,
  input  logic                                 in_last_pair,
  output logic                                 out_valid,
  output logic [darms_pkg::RMS_W-1:0]          out_rms_angle,
  output logic [darms_pkg::PC_W-1:0]           out_pair_count,
  output logic                                 out_count_overflow
);

  localparam int CNT_W   = $clog2(MAX_ANGLES + 1);
  localparam int DIFF_W  = darms_pkg::DIFF_W;
  localparam int SQ_W    = darms_pkg::SQ_W;
  localparam int CONST_W = darms_pkg::CONST_W;
  localparam int SUM_W   = darms_pkg::SUM_W;
  localparam int ROOT_W  = darms_pkg::ROOT_W;
  localparam int RMS_W   = darms_pkg::RMS_W;

  localparam logic [63:0] PI_RND =
    (darms_pkg::PI_SCALED_61 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_RND =
    (darms_pkg::PI_SCALED_61 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  localparam logic [CONST_W-1:0] PI_Q     = PI_RND[CONST_W-1:0];
  localparam logic [CONST_W-1:0] TWO_PI_Q = TWO_PI_RND[CONST_W-1:0];
  localparam logic [CNT_W-1:0]   CNT_MAX  = CNT_W'(MAX_ANGLES);

  darms_pkg::seq_state_t state_r, state_nxt;

  logic signed [darms_pkg::ANGLE_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic                last_r, last_nxt;
  logic [DIFF_W-1:0]   diff_r, diff_nxt;
  logic [DIFF_W-1:0]   wrap_r, wrap_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RMS_W-1:0]    rms_r, rms_nxt;
  logic [darms_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                ovo_r, ovo_nxt;

  logic                 unit_start;
  logic                 unit_done;
  logic [ROOT_W-1:0]    unit_root;

  logic signed [DIFF_W-1:0] d_s;
  logic [CONST_W-1:0]       diff_ext;
  logic [CONST_W-1:0]       wrap_full;
  logic [SUM_W:0]           sum_add;

  always_comb begin
    d_s       = DIFF_W'(b_r) - DIFF_W'(a_r);
    diff_ext  = CONST_W'(diff_r);
    if (diff_ext > PI_Q) begin
      wrap_full = (TWO_PI_Q >= diff_ext) ? TWO_PI_Q - diff_ext : diff_ext - TWO_PI_Q;
    end else begin
      wrap_full = diff_ext;
    end
    sum_add    = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);
    unit_start = (state_r == darms_pkg::ST_KICK);
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    diff_nxt      = diff_r;
    wrap_nxt      = wrap_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    rms_nxt       = rms_r;
    pc_nxt        = pc_r;
    ovo_nxt       = ovo_r;
    case (state_r)
      darms_pkg::ST_IDLE: begin
        if (start) begin
          a_nxt     = in_angle_a;
          b_nxt     = in_angle_b;
          last_nxt  = in_last_pair;
          state_nxt = darms_pkg::ST_DIFF;
        end
      end
      darms_pkg::ST_DIFF: begin
        diff_nxt  = d_s[DIFF_W-1] ? DIFF_W'(-d_s) : DIFF_W'(d_s);
        state_nxt = darms_pkg::ST_WRAP;
      end
      darms_pkg::ST_WRAP: begin
        wrap_nxt  = wrap_full[DIFF_W-1:0];
        state_nxt = darms_pkg::ST_MUL;
      end
      darms_pkg::ST_MUL: begin
        sq_nxt    = wrap_r * wrap_r;
        state_nxt = darms_pkg::ST_ACC;
      end
      darms_pkg::ST_ACC: begin
        if (cnt_r >= CNT_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = last_r ? darms_pkg::ST_KICK : darms_pkg::ST_IDLE;
      end
      darms_pkg::ST_KICK: begin
        state_nxt = darms_pkg::ST_WAIT;
      end
      darms_pkg::ST_WAIT: begin
        if (unit_done) begin
          rms_nxt       = (unit_root > ROOT_W'(darms_pkg::RMS_MAX)) ?
                          darms_pkg::RMS_MAX : unit_root[RMS_W-1:0];
          pc_nxt        = darms_pkg::PC_W'(cnt_r);
          ovo_nxt       = ovf_r;
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = darms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = darms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= darms_pkg::ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    last_r <= last_nxt;
    diff_r <= diff_nxt;
    wrap_r <= wrap_nxt;
    sq_r   <= sq_nxt;
    rms_r  <= rms_nxt;
    pc_r   <= pc_nxt;
    ovo_r  <= ovo_nxt;
  end

  // mean = sum / count, then truncated integer root
  darms_divsqrt #(
    .DIV_W (CNT_W)
  ) u_divsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (unit_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (unit_done),
    .root     (unit_root)
  );

  assign busy               = (state_r != darms_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_rms_angle      = rms_r;
  assign out_pair_count     = pc_r;
  assign out_count_overflow = ovo_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("pair count beyond its limit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cnt_r == '0 && sum_r == '0 && !ovf_r))
    else $error("running state not cleared with a result");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> (state_r == darms_pkg::ST_WAIT))
    else $error("root unit finished outside the wait state");

endmodule
